@@ hdl/pvp_pkg.sv @@
// ----------------------------------------------------------------------------
// pvp_pkg
// shared types, widths and helpers of the perspective vertex projection
// ----------------------------------------------------------------------------
package pvp_pkg;

    localparam int COORD_BITS  = 20;
    localparam int COEFF_BITS  = 16;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = DIFF_BITS + COEFF_BITS;
    localparam int R_BITS      = PROD_BITS + 2;
    localparam int MAG_BITS    = R_BITS - 1;
    localparam int FOCAL_BITS  = 16;
    localparam int P_BITS      = MAG_BITS + FOCAL_BITS;
    localparam int Q_BITS      = 22;
    localparam int D_BITS      = MAG_BITS + 3;
    localparam int ROW_BITS    = 3 * COEFF_BITS;
    localparam int CFG_BITS    = ROW_BITS;
    localparam int CFG_IDX_BITS = 3;
    localparam int HALF_BITS   = 12;
    localparam int PIX_BITS    = 16;
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int FRONT_STAGES = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_CAMERA_X   = 3'd0,
        REG_CAMERA_Y   = 3'd1,
        REG_CAMERA_Z   = 3'd2,
        REG_ROW_FIRST  = 3'd3,
        REG_ROW_SECOND = 3'd4,
        REG_ROW_THIRD  = 3'd5,
        REG_FOCAL      = 3'd6,
        REG_CENTER     = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [15:0]                   vertex_tag;
        logic signed [COORD_BITS-1:0]  vertex_x;
        logic signed [COORD_BITS-1:0]  vertex_y;
        logic signed [COORD_BITS-1:0]  vertex_z;
    } vertex_t;

    typedef struct packed {
        logic [15:0]                 result_tag;
        logic signed [PIX_BITS-1:0]  screen_x;
        logic signed [PIX_BITS-1:0]  screen_y;
        logic                        behind_camera;
        logic                        clipped;
    } result_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] cam_x;
        logic [COORD_BITS-1:0] cam_y;
        logic [COORD_BITS-1:0] cam_z;
        logic [ROW_BITS-1:0]   row0;
        logic [ROW_BITS-1:0]   row1;
        logic [ROW_BITS-1:0]   row2;
    } camera_t;

    typedef struct packed {
        logic [FOCAL_BITS-1:0]   focal;
        logic [2*HALF_BITS-1:0]  center;
    } screen_t;

    // camera-space item handed from front to back
    typedef struct packed {
        logic [15:0]              tag;
        logic signed [R_BITS-1:0] rx;
        logic signed [R_BITS-1:0] ry;
        logic signed [R_BITS-1:0] rz;
        logic                     behind;
    } cam_item_t;

    typedef struct packed {
        logic [D_BITS-1:0]  rem;
        logic [Q_BITS-1:0]  q;
        logic [Q_BITS-1:0]  plow;
        logic               neg;
        logic               big;
    } lane_t;

    typedef struct packed {
        logic               valid;
        logic [15:0]        tag;
        logic               behind;
        logic [D_BITS-1:0]  d;
        lane_t              lx;
        lane_t              ly;
    } div_stage_t;

    // one restoring division step
    function automatic lane_t div_step(lane_t l, logic [D_BITS-1:0] d);
        lane_t              o;
        logic [D_BITS:0]    sh;
        o = l;
        sh = {l.rem, l.plow[Q_BITS-1]};
        o.plow = {l.plow[Q_BITS-2:0], 1'b0};
        if (sh >= {1'b0, d})
        begin
            sh = sh - {1'b0, d};
            o.q = {l.q[Q_BITS-2:0], 1'b1};
        end
        else
        begin
            o.q = {l.q[Q_BITS-2:0], 1'b0};
        end
        o.rem = sh[D_BITS-1:0];
        return o;
    endfunction

    // round, add centre, saturate
    function automatic logic [PIX_BITS:0] finish(lane_t l, logic [HALF_BITS-1:0] half);
        logic [Q_BITS:0]           mag;
        logic signed [Q_BITS+2:0]  sum;
        logic                      clip;
        logic [PIX_BITS-1:0]       pix;
        if (l.big)
            mag = {1'b1, {Q_BITS{1'b0}}};
        else
            mag = ({1'b0, l.q} + {{Q_BITS{1'b0}}, 1'b1}) >> 1;
        sum = $signed({{(Q_BITS+3-HALF_BITS){1'b0}}, half});
        if (l.neg)
            sum = sum - $signed({2'b00, mag});
        else
            sum = sum + $signed({2'b00, mag});
        clip = 1'b0;
        pix = sum[PIX_BITS-1:0];
        if (sum > $signed((Q_BITS+3)'(32767)))
        begin
            clip = 1'b1;
            pix = 16'h7fff;
        end
        else if (sum < -$signed((Q_BITS+3)'(32768)))
        begin
            clip = 1'b1;
            pix = 16'h8000;
        end
        return {clip, pix};
    endfunction

endpackage

@@ hdl/pvp_front.sv @@
// ----------------------------------------------------------------------------
// pvp_front
// camera offset, 3x3 rotation and behind-camera classification
// ----------------------------------------------------------------------------
module pvp_front
    import pvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  vertex_t   vertex,
    input  camera_t   cam,
    output logic      out_valid,
    output cam_item_t out_item
);

    logic                        v1_reg, v2_reg, v3_reg;
    logic [15:0]                 tag1_reg, tag2_reg;
    logic signed [DIFF_BITS-1:0] d_reg [3];
    logic signed [DIFF_BITS-1:0] d_next [3];
    logic signed [PROD_BITS-1:0] p_reg [9];
    logic signed [PROD_BITS-1:0] p_next [9];
    cam_item_t                   item_reg, item_next;
    logic [ROW_BITS-1:0]         rows [3];

    assign rows[0] = cam.row0;
    assign rows[1] = cam.row1;
    assign rows[2] = cam.row2;

    always_comb
    begin
        d_next[0] = $signed({vertex.vertex_x[COORD_BITS-1], vertex.vertex_x})
                  - $signed({cam.cam_x[COORD_BITS-1], cam.cam_x});
        d_next[1] = $signed({vertex.vertex_y[COORD_BITS-1], vertex.vertex_y})
                  - $signed({cam.cam_y[COORD_BITS-1], cam.cam_y});
        d_next[2] = $signed({vertex.vertex_z[COORD_BITS-1], vertex.vertex_z})
                  - $signed({cam.cam_z[COORD_BITS-1], cam.cam_z});
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                p_next[3*r+c] = d_reg[c]
                              * $signed(rows[r][COEFF_BITS*c +: COEFF_BITS]);
            end
        end
        item_next.tag = tag2_reg;
        item_next.rx = R_BITS'(p_reg[0]) + R_BITS'(p_reg[1]) + R_BITS'(p_reg[2]);
        item_next.ry = R_BITS'(p_reg[3]) + R_BITS'(p_reg[4]) + R_BITS'(p_reg[5]);
        item_next.rz = R_BITS'(p_reg[6]) + R_BITS'(p_reg[7]) + R_BITS'(p_reg[8]);
        item_next.behind = item_next.rz[R_BITS-1] || (item_next.rz == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_reg <= vertex.vertex_tag;
        tag2_reg <= tag1_reg;
        d_reg    <= d_next;
        p_reg    <= p_next;
        item_reg <= item_next;
    end

    assign out_valid = v3_reg;
    assign out_item  = item_reg;

endmodule

@@ hdl/pvp_queue.sv @@
// ----------------------------------------------------------------------------
// pvp_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module pvp_queue
    import pvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cam_item_t push_item,
    input  logic      pop,
    output logic      not_empty,
    output cam_item_t pop_item,
    output logic      nearly_full
);

    cam_item_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_reg, rd_reg;
    logic [QUEUE_PTR_BITS:0]   level_reg, level_next;
    logic                      do_pop;

    assign do_pop    = pop && (level_reg != '0);
    assign not_empty = (level_reg != '0);
    assign pop_item  = mem_reg[rd_reg];
    // room kept for what the front still carries
    assign nearly_full = level_reg > (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH - 1 - FRONT_STAGES);

    always_comb
    begin
        level_next = level_reg;
        if (push && !do_pop)
            level_next = level_reg + 1'b1;
        else if (!push && do_pop)
            level_next = level_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (do_pop)
                rd_reg <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_item;
    end

endmodule

@@ hdl/pvp_back.sv @@
// ----------------------------------------------------------------------------
// pvp_back
// focal scaling, pipelined depth division, rounding and saturation
// ----------------------------------------------------------------------------
module pvp_back
    import pvp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  cam_item_t item,
    input  screen_t   scr,
    output logic      done,
    output result_t   result
);

    logic                  va_reg;
    logic [15:0]           taga_reg;
    logic                  behinda_reg, nxa_reg, nya_reg;
    logic [P_BITS-1:0]     px_reg, py_reg;
    logic [D_BITS-1:0]     da_reg;
    logic [MAG_BITS-1:0]   ax, ay;
    div_stage_t            st_reg [Q_BITS+1];
    div_stage_t            first_next;
    logic                  done_reg;
    result_t               res_reg, res_next;
    logic [PIX_BITS:0]     fx, fy;

    assign ax = item.rx[R_BITS-1] ? MAG_BITS'(-item.rx) : item.rx[MAG_BITS-1:0];
    assign ay = item.ry[R_BITS-1] ? MAG_BITS'(-item.ry) : item.ry[MAG_BITS-1:0];

    always_ff @(posedge clk)
    begin
        taga_reg    <= item.tag;
        behinda_reg <= item.behind;
        nxa_reg     <= item.rx[R_BITS-1];
        nya_reg     <= item.ry[R_BITS-1];
        px_reg      <= ax * scr.focal;
        py_reg      <= ay * scr.focal;
        da_reg      <= {item.rz[MAG_BITS-1:0], 3'b000};
    end

    // overflow test and remainder seed
    always_comb
    begin
        first_next.valid   = va_reg;
        first_next.tag     = taga_reg;
        first_next.behind  = behinda_reg;
        first_next.d       = da_reg;
        first_next.lx.big  = D_BITS'(px_reg[P_BITS-1:Q_BITS]) >= da_reg;
        first_next.ly.big  = D_BITS'(py_reg[P_BITS-1:Q_BITS]) >= da_reg;
        first_next.lx.rem  = first_next.lx.big ? '0 : D_BITS'(px_reg[P_BITS-1:Q_BITS]);
        first_next.ly.rem  = first_next.ly.big ? '0 : D_BITS'(py_reg[P_BITS-1:Q_BITS]);
        first_next.lx.plow = px_reg[Q_BITS-1:0];
        first_next.ly.plow = py_reg[Q_BITS-1:0];
        first_next.lx.q    = '0;
        first_next.ly.q    = '0;
        first_next.lx.neg  = nxa_reg;
        first_next.ly.neg  = nya_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg[0].valid <= 1'b0;
        else
            st_reg[0] <= first_next;
    end

    // one quotient bit per stage
    for (genvar s = 1; s <= Q_BITS; s++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_reg[s].valid <= 1'b0;
            else
            begin
                st_reg[s].valid  <= st_reg[s-1].valid;
                st_reg[s].tag    <= st_reg[s-1].tag;
                st_reg[s].behind <= st_reg[s-1].behind;
                st_reg[s].d      <= st_reg[s-1].d;
                st_reg[s].lx     <= div_step(st_reg[s-1].lx, st_reg[s-1].d);
                st_reg[s].ly     <= div_step(st_reg[s-1].ly, st_reg[s-1].d);
            end
        end
    end

    always_comb
    begin
        fx = finish(st_reg[Q_BITS].lx, scr.center[HALF_BITS-1:0]);
        fy = finish(st_reg[Q_BITS].ly, scr.center[2*HALF_BITS-1:HALF_BITS]);
        res_next.result_tag = st_reg[Q_BITS].tag;
        if (st_reg[Q_BITS].behind)
        begin
            res_next.screen_x      = '0;
            res_next.screen_y      = '0;
            res_next.behind_camera = 1'b1;
            res_next.clipped       = 1'b0;
        end
        else
        begin
            res_next.screen_x      = fx[PIX_BITS-1:0];
            res_next.screen_y      = fy[PIX_BITS-1:0];
            res_next.behind_camera = 1'b0;
            res_next.clipped       = fx[PIX_BITS] | fy[PIX_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= st_reg[Q_BITS].valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

@@ hdl/perspective_vertex_projection.sv @@
// ----------------------------------------------------------------------------
// perspective_vertex_projection
// world-space vertex to integer screen pixel projection
// ----------------------------------------------------------------------------
// usage
//   an item is taken at a rising edge with start high and busy low; one
//   vertex may be offered every cycle
//   each item gives one result on result, marked by done for one cycle;
//   results leave in the order the items came in
//   pipeline: 3 front stages, queue, scaling and seed registers, 22
//   division stages (one quotient bit each, two lanes), output register
//   throughput: one item per cycle, set by the fully pipelined divider
//   the receiver cannot stall; the back end drains the queue every cycle,
//   so busy stays low in normal use
//   configuration is written through cfg_we / cfg_index / cfg_data while
//   no item is in flight
//   reset clears the pipeline valid bits and the queue, and loads the
//   identity matrix, camera at origin, focal 300.0 and centre 300, 300
// ----------------------------------------------------------------------------
module perspective_vertex_projection
    import pvp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  vertex_t                 vertex,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    output logic                    done,
    output result_t                 result
);

    camera_t   cam_reg;
    screen_t   scr_reg;
    logic      accept;
    logic      f_valid;
    cam_item_t f_item;
    logic      q_avail;
    cam_item_t q_item;
    logic      q_full;

    assign accept = start && !busy;
    assign busy   = q_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg.cam_x <= '0;
            cam_reg.cam_y <= '0;
            cam_reg.cam_z <= '0;
            cam_reg.row0  <= ROW_BITS'(48'd16384);
            cam_reg.row1  <= ROW_BITS'(48'd1073741824);
            cam_reg.row2  <= ROW_BITS'(48'd70368744177664);
            scr_reg.focal <= 16'd4800;
            scr_reg.center <= 24'd1229100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_CAMERA_X:   cam_reg.cam_x  <= cfg_data[COORD_BITS-1:0];
                REG_CAMERA_Y:   cam_reg.cam_y  <= cfg_data[COORD_BITS-1:0];
                REG_CAMERA_Z:   cam_reg.cam_z  <= cfg_data[COORD_BITS-1:0];
                REG_ROW_FIRST:  cam_reg.row0   <= cfg_data[ROW_BITS-1:0];
                REG_ROW_SECOND: cam_reg.row1   <= cfg_data[ROW_BITS-1:0];
                REG_ROW_THIRD:  cam_reg.row2   <= cfg_data[ROW_BITS-1:0];
                REG_FOCAL:      scr_reg.focal  <= cfg_data[FOCAL_BITS-1:0];
                REG_CENTER:     scr_reg.center <= cfg_data[2*HALF_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // front: offset, rotation, depth sign
    pvp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .vertex    (vertex),
        .cam       (cam_reg),
        .out_valid (f_valid),
        .out_item  (f_item)
    );

    // queue parting front and back
    pvp_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (f_valid),
        .push_item   (f_item),
        .pop         (1'b1),
        .not_empty   (q_avail),
        .pop_item    (q_item),
        .nearly_full (q_full)
    );

    // back: scaling, division, output
    pvp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_avail),
        .item     (q_item),
        .scr      (scr_reg),
        .done     (done),
        .result   (result)
    );

endmodule
